// File: hdl/ste_pkg.sv
`default_nettype none

package ste_pkg;

    // field widths fixed by the item format
    localparam int VALUE_BITS   = 32;
    localparam int CHAN_BITS    = 4;
    localparam int TIME_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int DEB_BITS     = 8;
    localparam int HIT_BITS     = 8;
    localparam int CHANNELS_DEF = 16;

    localparam logic [HIT_BITS-1:0]  HIT_MAX    = 8'd255;
    localparam logic [FRAC_BITS-1:0] FRAC_RESET = 16'd3277;
    localparam logic [DEB_BITS-1:0]  DEB_RESET  = 8'd3;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_HYST_FRAC = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE  = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 1;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        LVL_OK    = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ALARM = 2'd2
    } t_level;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        t_value lo_warn;
        t_value hi_warn;
        t_value lo_alarm;
        t_value hi_alarm;
        logic   low_en;
        logic   high_en;
    } t_limits;

    typedef struct packed {
        logic                loaded;
        t_level              cur;
        t_level              pend;
        logic [HIT_BITS-1:0] hits;
    } t_chan_state;

    // table write commands for one item
    typedef struct packed {
        logic load;
        logic upd;
        logic clear;
    } t_tbl_wr;

    typedef struct packed {
        logic [1:0]           req;
        logic                 smp_valid;
        logic [CHAN_BITS-1:0] ch;
        t_value               value;
        logic [TIME_BITS-1:0] time_ms;
        t_limits              lim;
    } t_item;

    typedef struct packed {
        logic                 transition;
        logic [CHAN_BITS-1:0] ch;
        t_level               level_now;
        t_level               level_before;
        t_value               value;
        logic [TIME_BITS-1:0] time_ms;
        t_value               crossed;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/ste_table.sv
`default_nettype none

module ste_table
    import ste_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int IDX_W    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_tbl_wr          i_wr,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_limits          i_lim_wr,
    input  wire t_chan_state      i_st_wr,
    output t_limits               o_lim,
    output t_chan_state           o_st
);

    t_limits     r_lim [CHANNELS];
    t_chan_state r_st  [CHANNELS];

    // limit storage, written by a load only
    always_ff @(posedge i_clk) begin
        if (i_en && i_wr.load) begin
            r_lim[i_idx] <= i_lim_wr;
        end
    end

    // per-channel level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_st[i] <= '0;
            end
        end else if (i_en) begin
            priority if (i_wr.clear) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_st[i].cur  <= LVL_OK;
                    r_st[i].pend <= LVL_OK;
                    r_st[i].hits <= '0;
                end
            end else if (i_wr.load) begin
                r_st[i_idx] <= '{loaded: 1'b1, cur: LVL_OK, pend: LVL_OK, hits: '0};
            end else if (i_wr.upd) begin
                r_st[i_idx] <= i_st_wr;
            end
        end
    end

    // read port at the channel of the item in flight
    assign o_lim = r_lim[i_idx];
    assign o_st  = r_st[i_idx];

endmodule

`default_nettype wire

// File: hdl/ste_grade.sv
`default_nettype none

module ste_grade
    import ste_pkg::*;
(
    input  wire t_item                i_item,
    input  wire logic                 i_inrange,
    input  wire t_limits              i_lim,
    input  wire t_chan_state          i_st,
    input  wire logic [FRAC_BITS-1:0] i_frac,
    input  wire logic [DEB_BITS-1:0]  i_deb,
    output t_tbl_wr                   o_wr,
    output t_chan_state               o_st,
    output t_result                   o_res
);

    localparam int EXT_W  = VALUE_BITS + 2;
    localparam int PROD_W = VALUE_BITS - 1 + FRAC_BITS;

    // floor(limit * frac / 2^16) for a positive limit
    function automatic logic [VALUE_BITS-2:0] band_of(input t_value lim,
                                                       input logic [FRAC_BITS-1:0] frac);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(lim[VALUE_BITS-2:0]) * PROD_W'(frac);
        return prod[PROD_W-1:FRAC_BITS];
    endfunction

    function automatic logic signed [EXT_W-1:0] ext(input t_value v);
        return $signed({{2{v[VALUE_BITS-1]}}, v});
    endfunction

    // high side test, threshold lowered by the band under hysteresis
    function automatic logic over_lim(input t_value v, input t_value lim, input logic en,
                                      input logic hyst, input logic [FRAC_BITS-1:0] frac);
        logic signed [EXT_W-1:0] thr;
        thr = ext(lim);
        if (hyst && (lim > 0)) begin
            thr = ext(lim) - $signed({3'b000, band_of(lim, frac)});
        end
        return en && (ext(v) > thr);
    endfunction

    // low side test, threshold raised by the band under hysteresis
    function automatic logic under_lim(input t_value v, input t_value lim, input logic en,
                                       input logic hyst, input logic [FRAC_BITS-1:0] frac);
        logic signed [EXT_W-1:0] thr;
        thr = ext(lim);
        if (hyst && (lim > 0)) begin
            thr = ext(lim) + $signed({3'b000, band_of(lim, frac)});
        end
        return en && (ext(v) < thr);
    endfunction

    logic   hyst;
    logic   hit_alarm;
    logic   hit_warn;
    t_level grade;
    logic   active;
    logic   do_load;
    logic   do_clear;
    logic   chg;
    t_level now_lvl;
    t_value crossed;

    // classification against the limits
    always_comb begin
        hyst      = (i_st.cur != LVL_OK);
        hit_alarm = over_lim(i_item.value, i_lim.hi_alarm, i_lim.high_en, hyst, i_frac)
                 || under_lim(i_item.value, i_lim.lo_alarm, i_lim.low_en, hyst, i_frac);
        hit_warn  = over_lim(i_item.value, i_lim.hi_warn, i_lim.high_en, hyst, i_frac)
                 || under_lim(i_item.value, i_lim.lo_warn, i_lim.low_en, hyst, i_frac);
        if (hit_alarm) begin
            grade = LVL_ALARM;
        end else if (hit_warn) begin
            grade = LVL_WARN;
        end else begin
            grade = LVL_OK;
        end
    end

    // debounce and level change
    always_comb begin
        active   = (i_item.req == REQ_SAMPLE) && i_item.smp_valid && i_inrange && i_st.loaded;
        do_load  = (i_item.req == REQ_LOAD) && i_inrange;
        do_clear = (i_item.req == REQ_CLEAR);
        o_st     = i_st;
        chg      = 1'b0;
        crossed  = '0;

        if (active) begin
            if (grade == i_st.pend) begin
                o_st.hits = (i_st.hits == HIT_MAX) ? i_st.hits : i_st.hits + 1'b1;
            end else begin
                o_st.pend = grade;
                o_st.hits = HIT_BITS'(1);
            end
            chg = (o_st.pend != i_st.cur) && (o_st.hits >= i_deb);
            if (chg) begin
                o_st.cur = o_st.pend;
            end
        end

        // crossed limit on a change to warning or alarm
        if (chg) begin
            unique case (o_st.cur)
                LVL_ALARM: crossed = (i_lim.high_en && (i_item.value > i_lim.hi_alarm))
                                   ? i_lim.hi_alarm : i_lim.lo_alarm;
                LVL_WARN:  crossed = (i_lim.high_en && (i_item.value > i_lim.hi_warn))
                                   ? i_lim.hi_warn : i_lim.lo_warn;
                default:   crossed = '0;
            endcase
        end

        if (do_load || do_clear || !i_inrange || !i_st.loaded) begin
            now_lvl = LVL_OK;
        end else begin
            now_lvl = o_st.cur;
        end

        o_wr = '{load: do_load, upd: active, clear: do_clear};

        o_res.transition   = chg;
        o_res.ch           = i_item.ch;
        o_res.level_now    = now_lvl;
        o_res.level_before = chg ? i_st.cur : now_lvl;
        o_res.value        = i_item.value;
        o_res.time_ms      = i_item.time_ms;
        o_res.crossed      = crossed;
    end

endmodule

`default_nettype wire

// File: hdl/sensor_threshold_alert_engine.sv
// Path: an item is held in the input register and moves on to the result register
// when that register is empty or is being drained by the output.
// Throughput: one item per cycle while m_tready keeps the result register draining;
// the addressed channel's state is read, classified and written back in that stage.
// Reset: clears channel loaded flags, levels, pending levels and hit counts, and
// sets the configuration to defaults; the limit table holds no value until loaded.
`default_nettype none

module sensor_threshold_alert_engine
    import ste_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // channel_id, sample_value, sample_time_ms, low warning limit, high warning limit,
    // low alarm limit, high alarm limit, load_low_enable, load_high_enable, pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // req_type, sample_valid
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_channel, level_now, level_before, out_value, out_time_ms, crossed_limit
    output logic [M_TDATA_W-1:0]       m_tdata,
    // transition
    output logic [M_TUSER_W-1:0]       m_tuser
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [FRAC_BITS-1:0] r_frac;
    logic [DEB_BITS-1:0]  r_deb;
    logic                 r_in_vld;
    logic                 n_in_vld;
    t_item                r_in;
    t_item                n_in;
    logic                 r_out_vld;
    logic                 n_out_vld;
    t_result              r_out;

    logic        s_xfer;
    logic        adv;
    logic        inrange;
    logic [IDX_W-1:0] idx;
    t_limits     tbl_lim;
    t_chan_state tbl_st;
    t_chan_state upd_st;
    t_tbl_wr     wr;
    t_result     res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
            r_deb  <= DEB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HYST_FRAC: r_frac <= i_cfg_wdata[FRAC_BITS-1:0];
                CFG_DEBOUNCE:  r_deb  <= i_cfg_wdata[DEB_BITS-1:0];
            endcase
        end
    end

    // handshake: the stage advances when the result register is free or drains
    assign adv      = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || adv;
    assign s_xfer   = s_tvalid && s_tready;

    // unpack the input transfer
    always_comb begin
        n_in.req          = s_tuser[1:0];
        n_in.smp_valid    = s_tuser[2];
        n_in.ch           = s_tdata[3:0];
        n_in.value        = s_tdata[35:4];
        n_in.time_ms      = s_tdata[67:36];
        n_in.lim.lo_warn  = s_tdata[99:68];
        n_in.lim.hi_warn  = s_tdata[131:100];
        n_in.lim.lo_alarm = s_tdata[163:132];
        n_in.lim.hi_alarm = s_tdata[195:164];
        n_in.lim.low_en   = s_tdata[196];
        n_in.lim.high_en  = s_tdata[197];
    end

    always_comb begin
        if (s_xfer) begin
            n_in_vld = 1'b1;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
        if (adv) begin
            n_out_vld = 1'b1;
        end else if (m_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in <= n_in;
        end
    end

    assign inrange = (int'(r_in.ch) < CHANNELS);
    assign idx     = IDX_W'(r_in.ch);

    ste_table #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_wr     (wr),
        .i_idx    (idx),
        .i_lim_wr (r_in.lim),
        .i_st_wr  (upd_st),
        .o_lim    (tbl_lim),
        .o_st     (tbl_st)
    );

    ste_grade u_grade (
        .i_item    (r_in),
        .i_inrange (inrange),
        .i_lim     (tbl_lim),
        .i_st      (tbl_st),
        .i_frac    (r_frac),
        .i_deb     (r_deb),
        .o_wr      (wr),
        .o_st      (upd_st),
        .o_res     (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    // pack the output transfer
    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out.transition;
    assign m_tdata  = {r_out.crossed, r_out.time_ms, r_out.value,
                       r_out.level_before, r_out.level_now, r_out.ch};

    // a reported transition always changes the level
    a_trans_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[5:4] != m_tdata[7:6]))
        else $error("transition without level change");

    // without a transition both levels agree
    a_no_trans_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[5:4] == m_tdata[7:6]))
        else $error("level change without transition");

    // crossed limit only on a change to warning or alarm
    a_crossed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (!m_tuser[0] || (m_tdata[5:4] == LVL_OK))) |-> (m_tdata[103:72] == '0))
        else $error("crossed limit set without a change to warning or alarm");

    // both stages full and the output stalled: no new transfer taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && !r_in_vld))
        else $error("stage valid after reset");

endmodule

`default_nettype wire

// File: test/alert_checker.sv
`timescale 1ns / 1ps

module alert_checker
    import ste_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // channel_id, sample_value, sample_time_ms, low warning limit, high warning limit,
    // low alarm limit, high alarm limit, load_low_enable, load_high_enable, pad
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // req_type, sample_valid
    input  wire logic [S_TUSER_W-1:0]  i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // out_channel, level_now, level_before, out_value, out_time_ms, crossed_limit
    input  wire logic [M_TDATA_W-1:0]  i_m_tdata,
    // transition
    input  wire logic [M_TUSER_W-1:0]  i_m_tuser,
    output int                         o_fail_count,
    output int                         o_pending
);

    // shadow copy of the configuration and the channel table
    logic [FRAC_BITS-1:0] frac_reg;
    logic [DEB_BITS-1:0]  deb_reg;
    t_limits              lim_tbl   [CHANNELS_DEF];
    logic                 loaded_tbl[CHANNELS_DEF];
    t_level               cur_lvl   [CHANNELS_DEF];
    t_level               pend_lvl  [CHANNELS_DEF];
    logic [HIT_BITS-1:0]  hit_cnt   [CHANNELS_DEF];

    // expected alerts, oldest first
    t_result alert_q[$];
    t_result got_alert;
    t_result want_alert;
    t_item   in_item;

    // hysteresis band: floor(limit * frac / 65536), limit positive
    function automatic longint hyst_band(longint lim);
        return (lim >> 16) * longint'(frac_reg) + (((lim & 64'hFFFF) * longint'(frac_reg)) >> 16);
    endfunction

    function automatic logic above(t_value v, t_value lim, logic en, logic hy);
        longint l;
        l = lim;
        if (!en)
            return 1'b0;
        if (hy && l > 0)
            return longint'(v) > l - hyst_band(l);
        return longint'(v) > l;
    endfunction

    // the widened threshold may leave the value range; compared exactly
    function automatic logic below(t_value v, t_value lim, logic en, logic hy);
        longint l;
        l = lim;
        if (!en)
            return 1'b0;
        if (hy && l > 0)
            return longint'(v) < l + hyst_band(l);
        return longint'(v) < l;
    endfunction

    // alarm test first, then warning
    function automatic t_level classify(logic [CHAN_BITS-1:0] ch, t_value v);
        t_limits l;
        logic    hy;
        l  = lim_tbl[ch];
        hy = cur_lvl[ch] != LVL_OK;
        if (above(v, l.hi_alarm, l.high_en, hy) || below(v, l.lo_alarm, l.low_en, hy))
            return LVL_ALARM;
        if (above(v, l.hi_warn, l.high_en, hy) || below(v, l.lo_warn, l.low_en, hy))
            return LVL_WARN;
        return LVL_OK;
    endfunction

    // advance the shadow table by one item and return its alert record
    function automatic t_result predict_alert(t_item it);
        t_result r;
        t_level  nxt;
        t_level  prev;
        t_limits l;
        logic    moved;
        r          = '0;
        moved      = 1'b0;
        prev       = LVL_OK;
        r.ch       = it.ch;
        r.value    = it.value;
        r.time_ms  = it.time_ms;
        case (it.req)
            REQ_LOAD: begin
                lim_tbl[it.ch]    = it.lim;
                loaded_tbl[it.ch] = 1'b1;
                cur_lvl[it.ch]    = LVL_OK;
                pend_lvl[it.ch]   = LVL_OK;
                hit_cnt[it.ch]    = '0;
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CHANNELS_DEF; i++) begin
                    cur_lvl[i]  = LVL_OK;
                    pend_lvl[i] = LVL_OK;
                    hit_cnt[i]  = '0;
                end
            end
            REQ_SAMPLE: begin
                if (it.smp_valid && loaded_tbl[it.ch]) begin
                    nxt = classify(it.ch, it.value);
                    // saturating debounce counter
                    if (nxt == pend_lvl[it.ch]) begin
                        if (hit_cnt[it.ch] != HIT_MAX)
                            hit_cnt[it.ch] = hit_cnt[it.ch] + 1'b1;
                    end else begin
                        pend_lvl[it.ch] = nxt;
                        hit_cnt[it.ch]  = HIT_BITS'(1);
                    end
                    if (pend_lvl[it.ch] != cur_lvl[it.ch] && hit_cnt[it.ch] >= deb_reg) begin
                        prev            = cur_lvl[it.ch];
                        cur_lvl[it.ch]  = pend_lvl[it.ch];
                        moved           = 1'b1;
                        l               = lim_tbl[it.ch];
                        if (cur_lvl[it.ch] == LVL_ALARM)
                            r.crossed = (l.high_en && $signed(it.value) > $signed(l.hi_alarm))
                                        ? l.hi_alarm : l.lo_alarm;
                        else if (cur_lvl[it.ch] == LVL_WARN)
                            r.crossed = (l.high_en && $signed(it.value) > $signed(l.hi_warn))
                                        ? l.hi_warn : l.lo_warn;
                    end
                end
            end
            default: ;
        endcase
        r.transition   = moved;
        r.level_now    = loaded_tbl[it.ch] ? cur_lvl[it.ch] : LVL_OK;
        r.level_before = moved ? prev : r.level_now;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // watch both channels and the configuration port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frac_reg     = FRAC_RESET;
            deb_reg      = DEB_RESET;
            o_fail_count = 0;
            alert_q.delete();
            for (int i = 0; i < CHANNELS_DEF; i++) begin
                lim_tbl[i]    = '0;
                loaded_tbl[i] = 1'b0;
                cur_lvl[i]    = LVL_OK;
                pend_lvl[i]   = LVL_OK;
                hit_cnt[i]    = '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_HYST_FRAC)
                    frac_reg = i_cfg_wdata[FRAC_BITS-1:0];
                else if (i_cfg_addr == CFG_DEBOUNCE)
                    deb_reg = i_cfg_wdata[DEB_BITS-1:0];
            end

            // result transfer against the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got_alert.transition   = i_m_tuser[0];
                got_alert.ch           = i_m_tdata[3:0];
                got_alert.level_now    = t_level'(i_m_tdata[5:4]);
                got_alert.level_before = t_level'(i_m_tdata[7:6]);
                got_alert.value        = i_m_tdata[39:8];
                got_alert.time_ms      = i_m_tdata[71:40];
                got_alert.crossed      = i_m_tdata[103:72];
                if (alert_q.size() == 0) begin
                    $error("result with no expectation waiting, channel %0d", got_alert.ch);
                    o_fail_count++;
                end else begin
                    want_alert = alert_q.pop_front();
                    check_field("transition", 32'(want_alert.transition),
                                32'(got_alert.transition));
                    check_field("out_channel", 32'(want_alert.ch), 32'(got_alert.ch));
                    check_field("level_now", 32'(want_alert.level_now),
                                32'(got_alert.level_now));
                    check_field("level_before", 32'(want_alert.level_before),
                                32'(got_alert.level_before));
                    check_field("out_value", want_alert.value, got_alert.value);
                    check_field("out_time_ms", want_alert.time_ms, got_alert.time_ms);
                    check_field("crossed_limit", want_alert.crossed, got_alert.crossed);
                end
            end

            // input transfer: predict its alert
            if (i_s_tvalid && i_s_tready) begin
                in_item.req          = i_s_tuser[1:0];
                in_item.smp_valid    = i_s_tuser[2];
                in_item.ch           = i_s_tdata[3:0];
                in_item.value        = i_s_tdata[35:4];
                in_item.time_ms      = i_s_tdata[67:36];
                in_item.lim.lo_warn  = i_s_tdata[99:68];
                in_item.lim.hi_warn  = i_s_tdata[131:100];
                in_item.lim.lo_alarm = i_s_tdata[163:132];
                in_item.lim.hi_alarm = i_s_tdata[195:164];
                in_item.lim.low_en   = i_s_tdata[196];
                in_item.lim.high_en  = i_s_tdata[197];
                alert_q.push_back(predict_alert(in_item));
            end
        end
        o_pending = alert_q.size();
    end

endmodule

// File: test/tb_sensor_threshold_alert_engine.sv
`timescale 1ns / 1ps

module tb_sensor_threshold_alert_engine;
    import ste_pkg::*;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam t_value     Q_ONE        = 32'sh0001_0000;
    localparam t_value     V_MIN        = 32'sh8000_0000;
    localparam t_value     V_MAX        = 32'sh7FFF_FFFF;
    localparam int         HOLD_CYCLES  = 100;
    localparam int         STALL_LIMIT  = 3000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int fail_count;
    int pending;

    // idle rates in percent, hold-off request and stall counting
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    int cfg_deb_now = int'(DEB_RESET);

    // limits last loaded per channel, used to aim samples near them
    t_limits tb_lim   [CHANNELS_DEF];
    logic    tb_loaded[CHANNELS_DEF];

    always #5 clk = ~clk;

    sensor_threshold_alert_engine uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    alert_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sample item, random noise in the unused limit fields
    function automatic t_item sample_item(logic [CHAN_BITS-1:0] ch, t_value v);
        t_item it;
        it           = '0;
        it.req       = REQ_SAMPLE;
        it.smp_valid = 1'b1;
        it.ch        = ch;
        it.value     = v;
        it.time_ms   = $urandom();
        it.lim       = t_limits'({$urandom(), $urandom(), $urandom(), $urandom(),
                                  2'($urandom())});
        return it;
    endfunction

    function automatic t_item load_item(logic [CHAN_BITS-1:0] ch, t_value wl, t_value wh,
                                        t_value al, t_value ah, logic le, logic he);
        t_item it;
        it              = sample_item(ch, $urandom());
        it.req          = REQ_LOAD;
        it.smp_valid    = 1'($urandom_range(0, 1));
        it.lim.lo_warn  = wl;
        it.lim.hi_warn  = wh;
        it.lim.lo_alarm = al;
        it.lim.hi_alarm = ah;
        it.lim.low_en   = le;
        it.lim.high_en  = he;
        return it;
    endfunction

    // offer one item after an optional gap, return at its transfer
    task automatic send_item(t_item it);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tdata  <= {2'b00, it.lim.high_en, it.lim.low_en, it.lim.hi_alarm,
                     it.lim.lo_alarm, it.lim.hi_warn, it.lim.lo_warn,
                     it.time_ms, it.value, it.ch};
        s_tuser  <= {it.smp_valid, it.req};
        s_tvalid <= 1'b1;
        if (it.req == REQ_LOAD) begin
            tb_lim[it.ch]    = it.lim;
            tb_loaded[it.ch] = 1'b1;
        end
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and wait for every outstanding alert
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [FRAC_BITS-1:0] frac, logic [DEB_BITS-1:0] deb);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_HYST_FRAC;
        cfg_wdata <= frac;
        @(posedge clk);
        cfg_addr  <= CFG_DEBOUNCE;
        cfg_wdata <= CFG_DATA_W'(deb);
        @(posedge clk);
        cfg_we      <= 1'b0;
        cfg_deb_now = int'(deb);
    endtask

    // mostly bursts of samples, aimed at loaded channels and often near their limits
    task automatic run_random(int n, bit with_hold);
        int                   sent;
        int                   r;
        int                   len;
        int                   pick;
        bit                   held;
        logic [CHAN_BITS-1:0] ch;
        t_value               base;
        t_item                it;
        t_limits              l;
        sent = 0;
        held = 1'b0;
        while (sent < n) begin
            if (with_hold && !held && sent >= 20) begin
                hold_req++;
                held = 1'b1;
            end
            r  = $urandom_range(0, 99);
            ch = CHAN_BITS'($urandom_range(0, 15));
            if (r < 8) begin
                l.hi_warn  = $urandom_range(Q_ONE, 30 * Q_ONE);
                l.hi_alarm = l.hi_warn + $urandom_range(0, 20 * Q_ONE);
                l.lo_warn  = $urandom_range(0, 40 * Q_ONE) - 30 * Q_ONE;
                l.lo_alarm = l.lo_warn - $urandom_range(0, 20 * Q_ONE);
                if ($urandom_range(0, 9) == 0)
                    l = t_limits'({$urandom(), $urandom(), $urandom(), $urandom(), 2'b00});
                l.low_en  = ($urandom_range(0, 9) != 0);
                l.high_en = ($urandom_range(0, 9) != 0);
                send_item(load_item(ch, l.lo_warn, l.hi_warn, l.lo_alarm, l.hi_alarm,
                                    l.low_en, l.high_en));
                sent++;
            end else if (r < 10) begin
                it     = sample_item(ch, $urandom());
                it.req = REQ_CLEAR;
                send_item(it);
                sent++;
            end else if (r < 13) begin
                // reserved request type, ignored by the block
                it           = sample_item(ch, $urandom());
                it.req       = REQ_RESERVED;
                it.smp_valid = 1'($urandom_range(0, 1));
                send_item(it);
            end else begin
                repeat (4) if (!tb_loaded[ch]) ch = CHAN_BITS'($urandom_range(0, 15));
                l    = tb_lim[ch];
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    case ($urandom_range(0, 3))
                        0:       base = l.lo_warn;
                        1:       base = l.hi_warn;
                        2:       base = l.lo_alarm;
                        default: base = l.hi_alarm;
                    endcase
                    base = base + $urandom_range(0, 6 * Q_ONE) - 3 * Q_ONE;
                end else if (pick < 75) begin
                    base = $urandom_range(0, 80 * Q_ONE) - 40 * Q_ONE;
                end else if (pick < 90) begin
                    base = $urandom();
                end else begin
                    case ($urandom_range(0, 3))
                        0:       base = V_MIN;
                        1:       base = V_MAX;
                        2:       base = '0;
                        default: base = -1;
                    endcase
                end
                // long bursts when the debounce count is large
                if (cfg_deb_now > 8 && $urandom_range(0, 3) == 0)
                    len = cfg_deb_now + $urandom_range(1, 8);
                else
                    len = $urandom_range(1, 8);
                repeat (len) begin
                    it = sample_item(ch, base + $urandom_range(0, 16'h3000) - 16'h1800);
                    it.smp_valid = ($urandom_range(0, 19) != 0);
                    send_item(it);
                    if (it.smp_valid)
                        sent++;
                end
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        t_item it;
        for (int i = 0; i < CHANNELS_DEF; i++) begin
            tb_lim[i]    = '0;
            tb_loaded[i] = 1'b0;
        end
        tx_idle_pct = 38;
        rx_idle_pct = 83;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unloaded channel, then warning and alarm on the high side, alarm on the low side
        it = sample_item(4'd5, 15 * Q_ONE);
        it.time_ms = '0;
        send_item(it);
        send_item(load_item(4'd0, -10 * Q_ONE, 10 * Q_ONE, -20 * Q_ONE, 20 * Q_ONE,
                            1'b1, 1'b1));
        repeat (3) send_item(sample_item(4'd0, 15 * Q_ONE));
        repeat (3) send_item(sample_item(4'd0, 25 * Q_ONE));
        it = sample_item(4'd0, V_MIN);
        it.smp_valid = 1'b0;
        it.time_ms   = '1;
        send_item(it);
        // inside the hysteresis band of the high alarm
        repeat (3) send_item(sample_item(4'd0, 19 * Q_ONE));
        it = sample_item(4'd2, V_MAX);
        it.req = REQ_RESERVED;
        send_item(it);
        it = sample_item(4'd0, 0);
        it.req = REQ_CLEAR;
        send_item(it);
        repeat (3) send_item(sample_item(4'd0, V_MIN));
        send_item(sample_item(4'd0, V_MAX));
        // low side only, limit at the top of the range: band leaves the range
        send_item(load_item(4'd15, V_MAX, V_MIN, V_MAX, V_MIN, 1'b1, 1'b0));
        repeat (3) send_item(sample_item(4'd15, 0));
        repeat (2) send_item(sample_item(4'd15, V_MAX));
        // both sides disabled
        send_item(load_item(4'd3, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, 1'b0, 1'b0));
        send_item(sample_item(4'd3, 5 * Q_ONE));
        drain();

        set_config(16'hFFFF, 8'd0);
        run_random(80, 1'b1);
        drain();

        // a long burst past the debounce count may make up most of this run
        set_config(16'h0000, 8'd255);
        run_random(120, 1'b0);
        drain();

        tx_idle_pct = 83;
        rx_idle_pct = 38;
        set_config(FRAC_BITS'($urandom_range(1, 65534)), 8'd1);
        run_random(80, 1'b0);
        drain();

        set_config(FRAC_BITS'($urandom()), DEB_BITS'($urandom_range(0, 8)));
        run_random(80, 1'b0);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(FRAC_RESET, DEB_RESET);
        run_random(80, 1'b0);
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
